// File: rtl/multitap_keypad_decoder_unit_macros.svh
// Assertion macros for the multi-tap keypad decoder checker.
// Depends on a clk and an arst_n signal in the scope where a macro is used.
`ifndef MULTITAP_KEYPAD_DECODER_UNIT_MACROS_SVH
`define MULTITAP_KEYPAD_DECODER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define MKD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keypad decoder check failed");

// The consequent holds in the cycle after the antecedent.
`define MKD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keypad decoder check failed");

`endif

// File: rtl/mkd_pkg.sv
// Types, key codes and character tables of the multi-tap keypad decoder.
// Has no dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package mkd_pkg;

	typedef enum logic [2:0] {
		KIND_POLL,
		KIND_BKSP,
		KIND_NEWLINE,
		KIND_SPACE,
		KIND_SHIFT,
		KIND_DIGIT,
		KIND_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  digit;
	} cmd_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  byte_val;
	} emit_t;

	typedef struct packed {
		logic        pending;
		logic [3:0]  digit;
		logic [3:0]  pos;
		logic        shift;
	} status_t;

	localparam logic [7:0]  KEY_BKSP     = 8'h4D;
	localparam logic [7:0]  KEY_NEWLINE  = 8'h5A;
	localparam logic [7:0]  KEY_SPACE    = 8'h23;
	localparam logic [7:0]  KEY_SHIFT    = 8'h2A;
	localparam logic [7:0]  KEY_ZERO     = 8'h30;
	localparam logic [7:0]  KEY_NINE     = 8'h39;
	localparam logic [7:0]  BYTE_NEWLINE = 8'h0A;
	localparam logic [7:0]  BYTE_SPACE   = 8'h20;
	localparam logic [7:0]  LOWER_A      = 8'h61;
	localparam logic [7:0]  LOWER_Z      = 8'h7A;
	localparam logic [7:0]  CASE_OFFSET  = 8'h20;
	localparam logic [15:0] TIMEOUT_RESET = 16'd800;
	localparam int          QUEUE_DEPTH  = 2;
	localparam int          MAX_EMIT     = 3;

	// Entries below 16'h0100 are one byte, others are a two-byte UTF-8 sequence.
	localparam logic [15:0] CHAR_TABLE [0:9][0:9] = '{
		'{16'h0020, 16'h0030, 16'h0000, 16'h0000, 16'h0000,
		  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h002E, 16'h002C, 16'h003F, 16'h0021, 16'h0031,
		  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h0061, 16'h0062, 16'h0063, 16'h0032, 16'hD0B0,
		  16'hD0B1, 16'hD0B2, 16'hD0B3, 16'hD291, 16'h0000},
		'{16'h0064, 16'h0065, 16'h0066, 16'h0033, 16'hD0B4,
		  16'hD0B5, 16'hD194, 16'hD0B6, 16'hD0B7, 16'h0000},
		'{16'h0067, 16'h0068, 16'h0069, 16'h0034, 16'hD0B8,
		  16'hD196, 16'hD197, 16'hD0B9, 16'hD0BA, 16'hD0BB},
		'{16'h006A, 16'h006B, 16'h006C, 16'h0035, 16'hD0BC,
		  16'hD0BD, 16'hD0BE, 16'hD0BF, 16'h0000, 16'h0000},
		'{16'h006D, 16'h006E, 16'h006F, 16'h0036, 16'hD180,
		  16'hD181, 16'hD182, 16'hD183, 16'h0000, 16'h0000},
		'{16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0037,
		  16'hD184, 16'hD185, 16'hD186, 16'hD187, 16'h0000},
		'{16'h0074, 16'h0075, 16'h0076, 16'h0038, 16'hD188,
		  16'hD189, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h0077, 16'h0078, 16'h0079, 16'h007A, 16'h0039,
		  16'hD18C, 16'hD18E, 16'hD18F, 16'h0000, 16'h0000}
	};

	localparam logic [3:0] LIST_LEN [0:9] = '{
		4'd2, 4'd5, 4'd9, 4'd9, 4'd10, 4'd8, 4'd8, 4'd9, 4'd6, 4'd8
	};

endpackage

// File: rtl/mkd_front.sv
// Input stage of the keypad decoder: accepts items and sorts them by key class.
// Depends on mkd_pkg.
`timescale 1ns / 1ps

module mkd_front #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  mode,
	input  logic [7:0]            key_code,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mkd_pkg::cmd_t         out_cmd,
	output logic [TIME_BITS-1:0]  out_time
);
	import mkd_pkg::*;

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [TIME_BITS-1:0]  time_s1;
	cmd_t                  cmd_c;
	logic [63:0]           now_ext;
	logic                  load;

	assign full      = valid_s1 && !out_ready;
	assign load      = push && !full;
	assign out_valid = valid_s1;
	assign out_cmd   = cmd_s1;
	assign out_time  = time_s1;
	assign now_ext   = {32'd0, now_ms};

	always_comb begin
		cmd_c.digit = 4'd0;
		cmd_c.kind  = KIND_OTHER;
		if (mode) begin
			cmd_c.kind = KIND_POLL;
		end else if (key_code inside {[KEY_ZERO:KEY_NINE]}) begin
			cmd_c.kind  = KIND_DIGIT;
			cmd_c.digit = 4'(key_code - KEY_ZERO);
		end else begin
			case (key_code)
				KEY_BKSP:    cmd_c.kind = KIND_BKSP;
				KEY_NEWLINE: cmd_c.kind = KIND_NEWLINE;
				KEY_SPACE:   cmd_c.kind = KIND_SPACE;
				KEY_SHIFT:   cmd_c.kind = KIND_SHIFT;
				default:     cmd_c.kind = KIND_OTHER;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1  <= cmd_c;
			time_s1 <= now_ext[TIME_BITS-1:0];
		end
	end

endmodule

// File: rtl/mkd_queue.sv
// Short command queue between the front and back parts of the keypad decoder.
// Depends on mkd_pkg for its depth.
`timescale 1ns / 1ps

module mkd_queue #(
	parameter int WIDTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WIDTH-1:0]  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDTH-1:0]  out_data
);
	import mkd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_en;
	logic              rd_en;

	assign in_ready  = count_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign wr_en     = in_valid && in_ready;
	assign rd_en     = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

// File: rtl/mkd_back.sv
// Execution part of the keypad decoder: multi-tap state, commit logic, the
// result sequencer and the output register. Depends on mkd_pkg.
`timescale 1ns / 1ps

module mkd_back #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  mkd_pkg::cmd_t         cmd,
	input  logic [TIME_BITS-1:0]  cmd_time,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            action,
	output logic [7:0]            byte_value,
	output logic                  last,
	output logic                  pending,
	output logic [3:0]            pending_digit,
	output logic [3:0]            cycle_position,
	output logic                  shift_on
);
	import mkd_pkg::*;

	logic [15:0]           timeout_q;
	logic                  pend_q;
	logic [3:0]            held_q;
	logic [3:0]            idx_q;
	logic                  shift_q;
	logic [TIME_BITS-1:0]  last_time_q;

	emit_t                 ent_q [0:MAX_EMIT-1];
	logic [1:0]            cnt_q;
	logic [1:0]            pos_q;
	status_t               stat_q;
	logic                  busy_q;

	logic                  out_valid_q;
	emit_t                 out_ent_q;
	logic                  out_last_q;
	status_t               out_stat_q;

	logic                  move;
	logic                  pos_last;
	logic                  take;
	logic [63:0]           to_ext;
	logic [TIME_BITS-1:0]  to_t;
	logic [TIME_BITS-1:0]  elapsed;
	logic [15:0]           ch;
	logic                  ch_ok;
	logic [7:0]            low_byte;
	emit_t                 cb0;
	emit_t                 cb1;
	logic [1:0]            ccnt;
	logic                  do_commit;
	logic                  has_extra;
	emit_t                 x_ent;
	logic [1:0]            cnum;
	emit_t                 ent_n [0:MAX_EMIT-1];
	logic [1:0]            cnt_n;
	logic                  pend_n;
	logic [3:0]            held_n;
	logic [3:0]            idx_n;
	logic [3:0]            idx_inc;
	logic                  shift_n;
	logic [TIME_BITS-1:0]  last_time_n;
	status_t               stat_n;

	assign move      = busy_q && (!out_valid_q || pop);
	assign pos_last  = pos_q == (cnt_q - 2'd1);
	assign cmd_ready = !busy_q || (move && pos_last);
	assign take      = cmd_valid && cmd_ready;
	assign to_ext    = {48'd0, timeout_q};
	assign to_t      = to_ext[TIME_BITS-1:0];
	assign elapsed   = cmd_time - last_time_q;
	assign idx_inc   = idx_q + 4'd1;

	// The pending character, split into the bytes that a commit would emit.
	always_comb begin
		ch       = CHAR_TABLE[held_q][idx_q];
		ch_ok    = pend_q && (idx_q < LIST_LEN[held_q]);
		low_byte = ch[7:0];
		if (shift_q && (low_byte inside {[LOWER_A:LOWER_Z]})) begin
			low_byte = low_byte - CASE_OFFSET;
		end
		cb0  = '{ACT_INSERT, ch[15:8]};
		cb1  = '{ACT_INSERT, ch[7:0]};
		ccnt = 2'd2;
		if (!ch_ok) begin
			ccnt = 2'd0;
		end else if (ch[15:8] == 8'h00) begin
			cb0  = '{ACT_INSERT, low_byte};
			ccnt = 2'd1;
		end
	end

	always_comb begin
		do_commit   = 1'b0;
		has_extra   = 1'b0;
		x_ent       = '{ACT_NONE, 8'h00};
		pend_n      = pend_q;
		held_n      = held_q;
		idx_n       = idx_q;
		shift_n     = shift_q;
		last_time_n = last_time_q;
		case (cmd.kind)
			KIND_POLL: begin
				if (pend_q && (elapsed > to_t)) begin
					do_commit = 1'b1;
				end
			end
			KIND_BKSP: begin
				if (pend_q) begin
					pend_n = 1'b0;
				end else begin
					has_extra = 1'b1;
					x_ent     = '{ACT_DELETE, 8'h00};
				end
			end
			KIND_NEWLINE: begin
				do_commit = 1'b1;
				has_extra = 1'b1;
				x_ent     = '{ACT_INSERT, BYTE_NEWLINE};
			end
			KIND_SPACE: begin
				do_commit = 1'b1;
				has_extra = 1'b1;
				x_ent     = '{ACT_INSERT, BYTE_SPACE};
			end
			KIND_SHIFT: begin
				shift_n = !shift_q;
			end
			KIND_DIGIT: begin
				if (pend_q && (cmd.digit == held_q) && (elapsed < to_t)) begin
					idx_n = (idx_inc >= LIST_LEN[held_q]) ? 4'd0 : idx_inc;
				end else begin
					do_commit = 1'b1;
				end
				last_time_n = cmd_time;
			end
			default: begin
				do_commit = 1'b1;
			end
		endcase

		if (do_commit) begin
			pend_n = 1'b0;
			idx_n  = 4'd0;
		end
		if (cmd.kind == KIND_DIGIT && do_commit) begin
			pend_n = 1'b1;
			held_n = cmd.digit;
		end

		// Commit bytes come first, then the byte or command of the key itself.
		cnum     = do_commit ? ccnt : 2'd0;
		ent_n[0] = (cnum != 2'd0) ? cb0 : x_ent;
		ent_n[1] = (cnum == 2'd2) ? cb1 : x_ent;
		ent_n[2] = x_ent;
		cnt_n    = cnum + {1'b0, has_extra};
		if (cnt_n == 2'd0) begin
			cnt_n = 2'd1;
		end

		stat_n.pending = pend_n;
		stat_n.digit   = pend_n ? held_n : 4'd0;
		stat_n.pos     = pend_n ? idx_n : 4'd0;
		stat_n.shift   = shift_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			pend_q      <= 1'b0;
			held_q      <= 4'd0;
			idx_q       <= 4'd0;
			shift_q     <= 1'b0;
			last_time_q <= '0;
			busy_q      <= 1'b0;
			pos_q       <= 2'd0;
			cnt_q       <= 2'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (take) begin
				pend_q      <= pend_n;
				held_q      <= held_n;
				idx_q       <= idx_n;
				shift_q     <= shift_n;
				last_time_q <= last_time_n;
				cnt_q       <= cnt_n;
				pos_q       <= 2'd0;
				busy_q      <= 1'b1;
			end else if (move && pos_last) begin
				busy_q <= 1'b0;
			end else if (move) begin
				pos_q <= pos_q + 2'd1;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q  <= ent_n;
			stat_q <= stat_n;
		end
		if (move) begin
			out_ent_q  <= ent_q[pos_q];
			out_last_q <= pos_last;
			out_stat_q <= stat_q;
		end
	end

	assign empty          = !out_valid_q;
	assign action         = out_ent_q.action;
	assign byte_value     = out_ent_q.byte_val;
	assign last           = out_last_q;
	assign pending        = out_stat_q.pending;
	assign pending_digit  = out_stat_q.digit;
	assign cycle_position = out_stat_q.pos;
	assign shift_on       = out_stat_q.shift;

endmodule

// File: rtl/multitap_keypad_decoder_unit.sv
// Top level of the multi-tap keypad decoder.
// Depends on mkd_pkg, mkd_front, mkd_queue and mkd_back.
// Key presses and timer polls enter through a queue-style push port and
// results leave through a queue-style pop port, one item per result. An input
// that yields one result sustains one item per clock while results are taken.
// An input that yields several results holds the back part's result sequencer
// until each is moved out: two when a digit, poll or other key commits a
// two-byte character, three when it comes ahead of a space or newline.
// The front stage and the two-entry command queue absorb that while the
// output register waits. With no stall, the first result of an item passes
// the front stage, queue, back command registers and output register. The
// timeout register, written through cfg_we and cfg_wdata, resets to 800 ms.
`timescale 1ns / 1ps

module multitap_keypad_decoder_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic         mode,
	input  logic [7:0]   key_code,
	input  logic [31:0]  now_ms,
	output logic         empty,
	input  logic         pop,
	output logic [1:0]   action,
	output logic [7:0]   byte_value,
	output logic         last,
	output logic         pending,
	output logic [3:0]   pending_digit,
	output logic [3:0]   cycle_position,
	output logic         shift_on,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	import mkd_pkg::*;

	localparam int CMD_W = $bits(cmd_t) + TIME_BITS;

	logic                  fr_valid;
	logic                  fr_ready;
	cmd_t                  fr_cmd;
	logic [TIME_BITS-1:0]  fr_time;
	logic                  q_valid;
	logic                  q_ready;
	logic [CMD_W-1:0]      q_data;
	cmd_t                  bk_cmd;
	logic [TIME_BITS-1:0]  bk_time;

	mkd_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mode     (mode),
		.key_code (key_code),
		.now_ms   (now_ms),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.out_cmd  (fr_cmd),
		.out_time (fr_time)
	);

	mkd_queue #(
		.WIDTH(CMD_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  ({fr_cmd, fr_time}),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_data (q_data)
	);

	assign bk_cmd  = q_data[CMD_W-1:TIME_BITS];
	assign bk_time = q_data[TIME_BITS-1:0];

	mkd_back #(
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd_ready     (q_ready),
		.cmd           (bk_cmd),
		.cmd_time      (bk_time),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pop           (pop),
		.empty         (empty),
		.action        (action),
		.byte_value    (byte_value),
		.last          (last),
		.pending       (pending),
		.pending_digit (pending_digit),
		.cycle_position(cycle_position),
		.shift_on      (shift_on)
	);

endmodule

// File: rtl/mkd_checker.sv
// Port-level checks of the multi-tap keypad decoder, bound to the top level.
// Depends on mkd_pkg and multitap_keypad_decoder_unit_macros.svh.
`timescale 1ns / 1ps
`include "multitap_keypad_decoder_unit_macros.svh"

module mkd_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  logic         pop,
	input  logic [1:0]   action,
	input  logic [7:0]   byte_value,
	input  logic         last,
	input  logic         pending,
	input  logic [3:0]   pending_digit,
	input  logic [3:0]   cycle_position,
	input  logic         shift_on
);
	import mkd_pkg::*;

	// A waiting result stays in place until it is taken.
	`MKD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(byte_value) && $stable(action))

	// With nothing pending the digit and list position read as zero.
	`MKD_ASSERT_NOW(a_idle_status, !empty && !pending, pending_digit == 4'd0 && cycle_position == 4'd0)

	// An empty result or a delete command is always the only item of its input.
	`MKD_ASSERT_NOW(a_lone_item, !empty && (action == ACT_NONE || action == ACT_DELETE), last && byte_value == 8'h00)

	// A delete is only issued when no character is pending, and the digit stays in range.
	`MKD_ASSERT_NOW(a_delete_idle, !empty && (action == ACT_DELETE || pending), (action == ACT_DELETE) ? !pending : (pending_digit <= 4'd9 && cycle_position <= 4'd9))

endmodule

bind multitap_keypad_decoder_unit mkd_checker u_mkd_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the multi-tap keypad decoder unit.
// Depends on mkd_pkg and multitap_keypad_decoder_unit; predicts every result
// item from its own copy of the decoder state and checks them in order.
`timescale 1ns / 1ps

module tb_top;
	import mkd_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [7:0]  key;
		logic [31:0] stamp;
	} press_t;

	typedef struct packed {
		action_t     act;
		logic [7:0]  byte_v;
		logic        last;
		logic        pend;
		logic [3:0]  dig;
		logic [3:0]  pos;
		logic        shft;
	} result_t;

	// One entry per character; a high byte of zero means a single ASCII byte.
	localparam logic [15:0] GLYPHS [0:9][0:9] = '{
		'{16'h0020, 16'h0030, 16'h0000, 16'h0000, 16'h0000,
		  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h002E, 16'h002C, 16'h003F, 16'h0021, 16'h0031,
		  16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h0061, 16'h0062, 16'h0063, 16'h0032, 16'hD0B0,
		  16'hD0B1, 16'hD0B2, 16'hD0B3, 16'hD291, 16'h0000},
		'{16'h0064, 16'h0065, 16'h0066, 16'h0033, 16'hD0B4,
		  16'hD0B5, 16'hD194, 16'hD0B6, 16'hD0B7, 16'h0000},
		'{16'h0067, 16'h0068, 16'h0069, 16'h0034, 16'hD0B8,
		  16'hD196, 16'hD197, 16'hD0B9, 16'hD0BA, 16'hD0BB},
		'{16'h006A, 16'h006B, 16'h006C, 16'h0035, 16'hD0BC,
		  16'hD0BD, 16'hD0BE, 16'hD0BF, 16'h0000, 16'h0000},
		'{16'h006D, 16'h006E, 16'h006F, 16'h0036, 16'hD180,
		  16'hD181, 16'hD182, 16'hD183, 16'h0000, 16'h0000},
		'{16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0037,
		  16'hD184, 16'hD185, 16'hD186, 16'hD187, 16'h0000},
		'{16'h0074, 16'h0075, 16'h0076, 16'h0038, 16'hD188,
		  16'hD189, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
		'{16'h0077, 16'h0078, 16'h0079, 16'h007A, 16'h0039,
		  16'hD18C, 16'hD18E, 16'hD18F, 16'h0000, 16'h0000}
	};
	localparam logic [3:0] GLYPH_CNT [0:9] = '{
		4'd2, 4'd5, 4'd9, 4'd9, 4'd10, 4'd8, 4'd8, 4'd9, 4'd6, 4'd8
	};
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 62;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        mode = 1'b0;
	logic [7:0]  key_code = 8'h00;
	logic [31:0] now_ms = 32'h0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  action;
	logic [7:0]  byte_value;
	logic        last;
	logic        pending;
	logic [3:0]  pending_digit;
	logic [3:0]  cycle_position;
	logic        shift_on;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'h0;

	press_t      press_q[$];
	result_t     exp_q[$];
	int          n_errors = 0;
	int          idle_pct = 20;
	logic        hold_go = 1'b0;
	logic        snk_hold = 1'b0;
	logic [31:0] t_stamp = 32'h0;
	logic [15:0] tmo_set = 16'd800;
	int          n_queued = 0;

	// Predicted decoder state.
	logic        m_pend = 1'b0;
	logic [3:0]  m_dig = 4'd0;
	logic [3:0]  m_idx = 4'd0;
	logic        m_shift = 1'b0;
	logic [31:0] m_last = 32'h0;
	logic [15:0] m_tmo = 16'd800;
	action_t     out_act[$];
	logic [7:0]  out_byte[$];

	multitap_keypad_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.key_code(key_code),
		.now_ms(now_ms),
		.empty(empty),
		.pop(pop),
		.action(action),
		.byte_value(byte_value),
		.last(last),
		.pending(pending),
		.pending_digit(pending_digit),
		.cycle_position(cycle_position),
		.shift_on(shift_on),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		if (n_errors < 40)
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	function automatic void emit_byte(action_t a, logic [7:0] b);
		out_act.push_back(a);
		out_byte.push_back(b);
	endfunction

	function automatic void commit_char();
		logic [15:0] g;
		logic [7:0]  b;
		if (m_pend) begin
			g = GLYPHS[m_dig][m_idx];
			if (g[15:8] == 8'h00) begin
				b = g[7:0];
				if (m_shift && b >= LOWER_A && b <= LOWER_Z)
					b = b - CASE_OFFSET;
				emit_byte(ACT_INSERT, b);
			end else begin
				emit_byte(ACT_INSERT, g[15:8]);
				emit_byte(ACT_INSERT, g[7:0]);
			end
		end
		m_pend = 1'b0;
		m_idx = 4'd0;
	endfunction

	function automatic void decode_press(press_t p);
		logic [31:0] gap;
		logic [3:0]  d;
		result_t     r;
		int          k;
		gap = p.stamp - m_last;
		d = p.key[3:0];
		out_act.delete();
		out_byte.delete();
		if (p.mode) begin
			if (m_pend && gap > {16'd0, m_tmo})
				commit_char();
		end else if (p.key == KEY_BKSP) begin
			if (m_pend)
				m_pend = 1'b0;
			else
				emit_byte(ACT_DELETE, 8'h00);
		end else if (p.key == KEY_NEWLINE) begin
			commit_char();
			emit_byte(ACT_INSERT, BYTE_NEWLINE);
		end else if (p.key == KEY_SPACE) begin
			commit_char();
			emit_byte(ACT_INSERT, BYTE_SPACE);
		end else if (p.key == KEY_SHIFT) begin
			m_shift = !m_shift;
		end else if (p.key >= KEY_ZERO && p.key <= KEY_NINE) begin
			if (m_pend && d == m_dig && gap < {16'd0, m_tmo}) begin
				m_idx = m_idx + 4'd1;
				if (m_idx >= GLYPH_CNT[d])
					m_idx = 4'd0;
			end else begin
				commit_char();
				m_dig = d;
				m_idx = 4'd0;
				m_pend = 1'b1;
			end
			m_last = p.stamp;
		end else begin
			commit_char();
		end
		if (out_act.size() == 0)
			emit_byte(ACT_NONE, 8'h00);
		for (k = 0; k < out_act.size(); k++) begin
			r.act = out_act[k];
			r.byte_v = out_byte[k];
			r.last = (k == out_act.size() - 1);
			r.pend = m_pend;
			r.dig = m_pend ? m_dig : 4'd0;
			r.pos = m_pend ? m_idx : 4'd0;
			r.shft = m_shift;
			exp_q.push_back(r);
		end
	endfunction

	// Sampling side: register writes, accepted items and result checks.
	always @(posedge clk) begin
		result_t e;
		press_t  p;
		if (arst_n) begin
			if (cfg_we)
				m_tmo = cfg_wdata;
			if (push && !full) begin
				p.mode = mode;
				p.key = key_code;
				p.stamp = now_ms;
				decode_press(p);
				void'(press_q.pop_front());
			end
			if (pop && !empty) begin
				if (exp_q.size() == 0) begin
					report_mismatch("result item with none expected");
				end else begin
					e = exp_q.pop_front();
					if (action !== e.act)
						report_mismatch($sformatf("action %0d, expected %0d", action, e.act));
					if (byte_value !== e.byte_v)
						report_mismatch($sformatf("byte_value %0h, expected %0h",
							byte_value, e.byte_v));
					if (last !== e.last)
						report_mismatch($sformatf("last %0b, expected %0b", last, e.last));
					if (pending !== e.pend)
						report_mismatch($sformatf("pending %0b, expected %0b", pending, e.pend));
					if (pending_digit !== e.dig)
						report_mismatch($sformatf("pending_digit %0d, expected %0d",
							pending_digit, e.dig));
					if (cycle_position !== e.pos)
						report_mismatch($sformatf("cycle_position %0d, expected %0d",
							cycle_position, e.pos));
					if (shift_on !== e.shft)
						report_mismatch($sformatf("shift_on %0b, expected %0b", shift_on, e.shft));
				end
			end
		end
	end

	// Driver: offers the oldest pending item unless it idles this cycle.
	always @(negedge clk) begin
		if (arst_n && press_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
			push <= 1'b1;
			mode <= press_q[0].mode;
			key_code <= press_q[0].key;
			now_ms <= press_q[0].stamp;
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: pops unless it idles or is held off.
	always @(negedge clk) begin
		pop <= arst_n && !snk_hold && ($urandom_range(99) >= idle_pct);
	end

	initial begin
		wait (hold_go);
		snk_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		snk_hold = 1'b0;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	task automatic queue_press(logic m, logic [7:0] k, logic [31:0] dt);
		press_t p;
		t_stamp = t_stamp + dt;
		p.mode = m;
		p.key = k;
		p.stamp = t_stamp;
		press_q.push_back(p);
		n_queued++;
	endtask

	function automatic logic [31:0] below_timeout();
		if (tmo_set == 16'd0)
			return 32'd0;
		return $urandom_range({16'd0, tmo_set} - 32'd1);
	endfunction

	function automatic logic [31:0] pick_gap();
		logic [31:0] t;
		t = {16'd0, tmo_set};
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return below_timeout();
			5: return t - 32'd1;
			6: return t;
			7: return t + 32'd1;
			8: return $urandom;
			default: return $urandom_range(t * 3 + 3, t + 1);
		endcase
	endfunction

	task automatic gen_burst();
		int         sel;
		int         n;
		logic [7:0] dkey;
		sel = $urandom_range(99);
		if (sel < 60) begin
			dkey = KEY_ZERO + 8'($urandom_range(9));
			n = $urandom_range(12, 1);
			queue_press(1'b0, dkey, pick_gap());
			repeat (n - 1)
				queue_press(1'b0, dkey, ($urandom_range(99) < 85) ? below_timeout() : pick_gap());
			case ($urandom_range(5))
				0: queue_press(1'b1, 8'($urandom), {16'd0, tmo_set} + 32'd1 + $urandom_range(50));
				1: queue_press(1'b1, 8'($urandom), pick_gap());
				2: queue_press(1'b0, KEY_SPACE, pick_gap());
				3: queue_press(1'b0, KEY_NEWLINE, pick_gap());
				4: queue_press(1'b0, KEY_BKSP, pick_gap());
				default: ;
			endcase
		end else if (sel < 70) begin
			queue_press(1'b0, KEY_SHIFT, pick_gap());
		end else if (sel < 78) begin
			queue_press(1'b0, KEY_BKSP, pick_gap());
		end else if (sel < 86) begin
			queue_press(1'b1, 8'($urandom), pick_gap());
		end else if (sel < 94) begin
			queue_press(1'b0, 8'($urandom), pick_gap());
		end else begin
			queue_press(1'b0, ($urandom_range(1) != 0) ? KEY_SPACE : KEY_NEWLINE, pick_gap());
		end
	endtask

	task automatic settle();
		while (press_q.size() != 0 || exp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_timeout(logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tmo_set = v;
	endtask

	initial begin
		logic [15:0] tmo_plan [7];
		int          ph;
		tmo_plan = '{16'd1, 16'd65535, 16'd0, 16'd800, 16'($urandom), 16'd3,
			16'($urandom_range(2000, 2))};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sequence at the reset timeout of 800 ms.
		queue_press(1'b0, KEY_BKSP, 32'd10);
		queue_press(1'b0, KEY_ZERO + 8'd2, 32'd90);
		queue_press(1'b0, KEY_ZERO + 8'd2, 32'd100);
		queue_press(1'b0, KEY_SHIFT, 32'd5);
		queue_press(1'b0, KEY_ZERO + 8'd2, 32'd795);
		queue_press(1'b1, 8'h00, 32'd800);
		queue_press(1'b1, 8'h00, 32'd1);
		queue_press(1'b0, KEY_ZERO, 32'd5);
		queue_press(1'b0, KEY_ZERO, 32'd5);
		queue_press(1'b0, KEY_NEWLINE, 32'd5);
		repeat (5) queue_press(1'b0, KEY_ZERO + 8'd2, 32'd3);
		queue_press(1'b0, KEY_SPACE, 32'd3);
		queue_press(1'b0, KEY_ZERO + 8'd9, 32'd10);
		queue_press(1'b0, KEY_BKSP, 32'd10);
		queue_press(1'b0, KEY_ZERO + 8'd5, 32'd10);
		queue_press(1'b0, 8'hFF, 32'd10);
		queue_press(1'b0, 8'h00, 32'd10);
		queue_press(1'b1, 8'hFF, 32'd5000);
		t_stamp = 32'hFFFF_FF00;
		queue_press(1'b0, KEY_ZERO + 8'd3, 32'h60);
		queue_press(1'b0, KEY_ZERO + 8'd3, 32'h40);
		queue_press(1'b0, KEY_BKSP, 32'h10);

		for (ph = 0; ph < 7; ph++) begin
			settle();
			write_timeout(tmo_plan[ph]);
			idle_pct = (ph == 3) ? 0 : 20;
			if (ph == 4)
				t_stamp = $urandom;
			if (ph == 1)
				hold_go = 1'b1;
			n_queued = 0;
			while (n_queued < PHASE_ITEMS)
				gen_burst();
		end
		settle();
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/mkd_pkg.sv
rtl/mkd_front.sv
rtl/mkd_queue.sv
rtl/mkd_back.sv
rtl/multitap_keypad_decoder_unit.sv
rtl/mkd_checker.sv
tb/tb_top.sv
